@@ rtl/spq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg: shared types and codes for the sorted priority queue
// Holds the entry type, the per-cell control bundle and the opcode and
// status codes used by the cell row and the top level.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int KEY_W        = 32;
  localparam int PAY_W        = 32;
  localparam int COUNT_W      = 5;
  localparam int STATUS_W     = 2;
  localparam int DEF_CAPACITY = 16;

  // Opcodes of an input request.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REMOVED  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

  // One stored entry.
  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [PAY_W-1:0]        payload;
  } spq_entry_t;

  // Operation broadcast to every cell in the row.
  typedef struct packed {
    logic ins_en;
    logic rem_en;
  } spq_ctrl_t;

endpackage

@@ rtl/sorted_priority_queue_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit: sorted insertion priority queue
// A row of CAPACITY cells keeps entries in ascending signed key order. An
// insert places the entry after all equal keys; a remove returns the head.
//
//   Channel   Direction  Handshake           Fields
//   in_       input      in_valid/in_ready   opcode, key, payload
//   out_      output     out_valid/out_ready status, out_key, out_payload, count
//
// For each request, every cell compares its key with the new key in
// parallel and the whole row shifts at the same clock edge.
// The result is held in an output register; a new request is taken while
// that register is empty or being emptied in the same cycle.
// Reset (synchronous, rst_n low) empties the queue and the output register;
// no clearing pass is needed. A stalled output holds off new requests.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit #(
  parameter int CAPACITY = spq_pkg::DEF_CAPACITY
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_opcode,
  input  logic signed [spq_pkg::KEY_W-1:0] in_key,
  input  logic [spq_pkg::PAY_W-1:0]        in_payload,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [spq_pkg::STATUS_W-1:0]     out_status,
  output logic signed [spq_pkg::KEY_W-1:0] out_key,
  output logic [spq_pkg::PAY_W-1:0]        out_payload,
  output logic [spq_pkg::COUNT_W-1:0]      out_count
);
  import spq_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]         count_r;
  logic [CW-1:0]         count_nxt;
  logic                  in_fire;
  logic                  is_full;
  logic                  is_empty;
  spq_ctrl_t             ctrl;
  spq_entry_t            new_entry;
  spq_entry_t            cell_entry [CAPACITY];
  logic [CAPACITY-1:0]   cell_ins;

  logic                  out_valid_r;
  logic [STATUS_W-1:0]   out_status_r;
  logic [STATUS_W-1:0]   out_status_nxt;
  logic signed [KEY_W-1:0] out_key_r;
  logic signed [KEY_W-1:0] out_key_nxt;
  logic [PAY_W-1:0]      out_payload_r;
  logic [PAY_W-1:0]      out_payload_nxt;
  logic [COUNT_W-1:0]    out_count_r;

  // Request handshake: free output slot or one being taken now.
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign is_full  = (count_r == CW'(CAPACITY));
  assign is_empty = (count_r == '0);

  // Operation for the cell row.
  assign ctrl.ins_en = in_fire && (in_opcode == OP_INSERT) && !is_full;
  assign ctrl.rem_en = in_fire && (in_opcode == OP_REMOVE) && !is_empty;

  assign new_entry.key     = in_key;
  assign new_entry.payload = in_payload;

  // Row of cells; each sees the new entry and its neighbors only.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    localparam logic [CW-1:0] IDX = CW'(g);
    spq_entry_t left_e;
    spq_entry_t right_e;
    logic       left_i;

    if (g == 0) begin : g_first
      assign left_e = new_entry;
      assign left_i = 1'b0;
    end else begin : g_mid
      assign left_e = cell_entry[g-1];
      assign left_i = cell_ins[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_e = cell_entry[g];
    end else begin : g_inner
      assign right_e = cell_entry[g+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occ         (IDX < count_r),
      .new_entry   (new_entry),
      .left_entry  (left_e),
      .left_ins    (left_i),
      .right_entry (right_e),
      .entry       (cell_entry[g]),
      .ins         (cell_ins[g])
    );
  end

  // Next count and result fields.
  always_comb begin
    count_nxt       = count_r;
    out_key_nxt     = '0;
    out_payload_nxt = '0;
    if (in_opcode == OP_INSERT) begin
      if (is_full) begin
        out_status_nxt = ST_FULL;
      end else begin
        out_status_nxt = ST_INSERTED;
        count_nxt      = count_r + CW'(1);
      end
    end else begin
      if (is_empty) begin
        out_status_nxt = ST_EMPTY;
      end else begin
        out_status_nxt  = ST_REMOVED;
        out_key_nxt     = cell_entry[0].key;
        out_payload_nxt = cell_entry[0].payload;
        count_nxt       = count_r - CW'(1);
      end
    end
  end

  // Control state: entry count and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_status_r  <= out_status_nxt;
      out_key_r     <= out_key_nxt;
      out_payload_r <= out_payload_nxt;
      out_count_r   <= COUNT_W'(count_nxt);
    end
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_key     = out_key_r;
  assign out_payload = out_payload_r;
  assign out_count   = out_count_r;

  // The stored count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // Every accepted request yields a held result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted request produced no result");

  // A remove on an empty queue reports zero entries and a zero key.
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == ST_EMPTY)) |-> (out_count_r == '0 && out_key_r == '0))
    else $error("empty result carries data");

  // A removal lowers the count by one.
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.rem_en) |=> (count_r == $past(count_r) - CW'(1)))
    else $error("count not decremented on removal");

endmodule

@@ rtl/spq_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted shift-register queue
// Holds one entry, compares it against the incoming key, and on each
// operation keeps its entry, loads the new entry, or takes the entry of its
// left or right neighbor.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic               clk,
  input  spq_pkg::spq_ctrl_t ctrl,
  input  logic               occ,
  input  spq_pkg::spq_entry_t new_entry,
  input  spq_pkg::spq_entry_t left_entry,
  input  logic               left_ins,
  input  spq_pkg::spq_entry_t right_entry,
  output spq_pkg::spq_entry_t entry,
  output logic               ins
);
  import spq_pkg::*;

  spq_entry_t entry_r;
  spq_entry_t entry_nxt;

  // The new entry belongs at or before this slot when the slot is free or
  // holds a strictly larger key, so equal keys stay ahead of it.
  assign ins = !occ || ($signed(entry_r.key) > $signed(new_entry.key));

  // Insert shifts right from the insertion point; remove shifts left.
  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.ins_en && ins) begin
      entry_nxt = left_ins ? left_entry : new_entry;
    end else if (ctrl.rem_en) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule
